// ----- src/lz77_window_decoder_core_assert.svh -----
// assertion macros used by the checker of the window decoder
`ifndef LZ77_WINDOW_DECODER_CORE_ASSERT_SVH
`define LZ77_WINDOW_DECODER_CORE_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define LZWD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define LZWD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- src/lzwd_pkg.sv -----
`default_nettype none

package lzwd_pkg;

  localparam int DEF_WINDOW    = 1024;
  localparam int DEF_MAX_MATCH = 16;

  localparam int BYTE_W = 8;
  localparam int OFF_W  = 10;
  localparam int LEN_W  = 4;

  // per-byte control that travels with a history read
  typedef struct packed {
    logic lit;   // literal byte, ends the run
    logic fill;  // copy reaches past written history
  } byte_ctrl_t;

endpackage

`default_nettype wire

// ----- src/lzwd_ram.sv -----
`default_nettype none

module lzwd_ram #(
  parameter int DEPTH = lzwd_pkg::DEF_WINDOW
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [$clog2(DEPTH)-1:0]             waddr_i,
  input  wire logic [lzwd_pkg::BYTE_W-1:0]          wdata_i,
  input  wire logic                                 re_i,
  input  wire logic [$clog2(DEPTH)-1:0]             raddr_i,
  output logic      [lzwd_pkg::BYTE_W-1:0]          rdata_o
);
  import lzwd_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  // read-before-write: a same-cycle read of the written slot returns old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/lzwd_seq.sv -----
`default_nettype none

module lzwd_seq #(
  parameter int WINDOW    = lzwd_pkg::DEF_WINDOW,
  parameter int MAX_MATCH = lzwd_pkg::DEF_MAX_MATCH
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [lzwd_pkg::OFF_W-1:0]        match_offset_i,
  input  wire logic [lzwd_pkg::LEN_W-1:0]        match_length_i,
  input  wire logic [lzwd_pkg::BYTE_W-1:0]       literal_i,
  input  wire logic                              new_stream_i,
  input  wire logic                              issue_ok_i,
  output logic                                   issue_o,
  output logic      [$clog2(WINDOW)-1:0]         raddr_o,
  output logic      [$clog2(WINDOW)-1:0]         waddr_o,
  output lzwd_pkg::byte_ctrl_t                   ctrl_o,
  output logic      [lzwd_pkg::BYTE_W-1:0]       lit_o
);
  import lzwd_pkg::*;

  localparam int AW  = $clog2(WINDOW);
  localparam int CW  = $clog2(WINDOW + 1);
  localparam int DW  = (CW > OFF_W) ? CW : OFF_W;
  localparam int LW  = (MAX_MATCH > 1) ? $clog2(MAX_MATCH) : 1;
  localparam int LCW = 7;

  logic              busy_q, busy_d;
  logic [CW-1:0]     dist_q, dist_d;
  logic [LW-1:0]     rem_q, rem_d;
  logic [BYTE_W-1:0] lit_q, lit_d;
  logic [AW-1:0]     wp_q, wp_d;
  logic [CW-1:0]     bw_q, bw_d;

  logic              accept;
  logic [DW-1:0]     off_ext, off_sat, dist_full;
  logic [LCW-1:0]    len_ext, len_sat;
  logic [CW:0]       wp_x, dist_x, idx_x;

  assign accept     = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;
  assign issue_o    = busy_q && issue_ok_i;

  always_comb begin
    off_ext   = DW'(match_offset_i);
    off_sat   = (off_ext >= DW'(WINDOW)) ? DW'(WINDOW - 1) : off_ext;
    dist_full = DW'(WINDOW) - off_sat;
    len_ext   = LCW'(match_length_i);
    len_sat   = (len_ext > LCW'(MAX_MATCH - 1)) ? LCW'(MAX_MATCH - 1) : len_ext;
  end

  // history slot dist bytes behind the write pointer, modulo the window
  always_comb begin
    wp_x   = (CW + 1)'(wp_q);
    dist_x = (CW + 1)'(dist_q);
    if (wp_x >= dist_x) begin
      idx_x = wp_x - dist_x;
    end else begin
      idx_x = wp_x + (CW + 1)'(WINDOW) - dist_x;
    end
  end

  assign raddr_o     = AW'(idx_x);
  assign waddr_o     = wp_q;
  assign lit_o       = lit_q;
  assign ctrl_o.lit  = (rem_q == '0);
  assign ctrl_o.fill = (dist_q > bw_q);

  always_comb begin
    busy_d = busy_q;
    dist_d = dist_q;
    rem_d  = rem_q;
    lit_d  = lit_q;
    wp_d   = wp_q;
    bw_d   = bw_q;
    if (accept) begin
      busy_d = 1'b1;
      dist_d = CW'(dist_full);
      rem_d  = LW'(len_sat);
      lit_d  = literal_i;
      if (new_stream_i) begin
        wp_d = '0;
        bw_d = '0;
      end
    end else if (issue_o) begin
      wp_d = (wp_q == AW'(WINDOW - 1)) ? '0 : wp_q + AW'(1);
      bw_d = (bw_q == CW'(WINDOW)) ? bw_q : bw_q + CW'(1);
      if (rem_q == '0) begin
        busy_d = 1'b0;
      end else begin
        rem_d = rem_q - LW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rem_q  <= '0;
      wp_q   <= '0;
      bw_q   <= '0;
    end else begin
      busy_q <= busy_d;
      rem_q  <= rem_d;
      wp_q   <= wp_d;
      bw_q   <= bw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
    lit_q  <= lit_d;
  end

endmodule

`default_nettype wire

// ----- src/lzwd_out.sv -----
`default_nettype none

module lzwd_out #(
  parameter int WINDOW = lzwd_pkg::DEF_WINDOW
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [lzwd_pkg::BYTE_W-1:0]       cfg_wdata_i,
  input  wire logic                              issue_i,
  input  wire logic [$clog2(WINDOW)-1:0]         raddr_i,
  input  wire logic [$clog2(WINDOW)-1:0]         waddr_i,
  input  wire lzwd_pkg::byte_ctrl_t              ctrl_i,
  input  wire logic [lzwd_pkg::BYTE_W-1:0]       lit_i,
  output logic                                   issue_ok_o,
  input  wire logic [lzwd_pkg::BYTE_W-1:0]       rdata_i,
  output logic                                   we_o,
  output logic      [$clog2(WINDOW)-1:0]         waddr_o,
  output logic      [lzwd_pkg::BYTE_W-1:0]       wdata_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [lzwd_pkg::BYTE_W-1:0]       data_byte_o,
  output logic                                   last_o
);
  import lzwd_pkg::*;

  localparam int AW = $clog2(WINDOW);

  logic [BYTE_W-1:0] fill_sym_q;
  logic              b_valid_q;
  byte_ctrl_t        b_ctrl_q;
  logic              b_fwd_q;
  logic [BYTE_W-1:0] b_lit_q;
  logic [AW-1:0]     b_waddr_q;
  logic              out_valid_q;
  logic [BYTE_W-1:0] data_q;
  logic              last_q;

  logic              b_fire;
  logic              fwd_d;
  logic [BYTE_W-1:0] byte_val;

  assign b_fire     = b_valid_q && (!out_valid_q || !out_stall_i);
  assign issue_ok_o = !b_valid_q || b_fire;

  // slot being written this edge is read stale by the memory, take it from data_q
  assign fwd_d = b_fire && (raddr_i == b_waddr_q);

  always_comb begin
    if (b_ctrl_q.lit) begin
      byte_val = b_lit_q;
    end else if (b_ctrl_q.fill) begin
      byte_val = fill_sym_q;
    end else if (b_fwd_q) begin
      byte_val = data_q;
    end else begin
      byte_val = rdata_i;
    end
  end

  assign we_o    = b_fire;
  assign waddr_o = b_waddr_q;
  assign wdata_o = byte_val;

  assign out_valid_o = out_valid_q;
  assign data_byte_o = data_q;
  assign last_o      = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_sym_q  <= '0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fill_sym_q <= cfg_wdata_i;
      end
      if (issue_i) begin
        b_valid_q <= 1'b1;
      end else if (b_fire) begin
        b_valid_q <= 1'b0;
      end
      if (b_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      b_ctrl_q  <= ctrl_i;
      b_fwd_q   <= fwd_d;
      b_lit_q   <= lit_i;
      b_waddr_q <= waddr_i;
    end
    if (b_fire) begin
      data_q <= byte_val;
      last_q <= b_ctrl_q.lit;
    end
  end

endmodule

`default_nettype wire

// ----- src/lz77_window_decoder_core.sv -----
// lz77 window decoder: one parsed token (offset, length, literal, new-stream
// flag) per request on the input channel, one decoded byte per request on
// the output channel. a token yields min(length, MAX_MATCH-1) bytes copied
// from the history window, then its literal with last_o set.
// copy distance is WINDOW - offset; history never written in the current
// stream reads as the fill byte taken from cfg_wdata_i when cfg_we_i is high.
// timing: in_stall_o goes high after a request and stays high while the
// token's bytes are issued, one history read per cycle unless the output
// stalls; a new request is taken only after the literal is issued. the
// first byte passes the sequencer, the issue buffer and the output
// register, later bytes follow one per cycle while out_stall_i is low.
// a stall on the output holds the output register and the byte behind it,
// which halts issue of further reads until the stall clears.
// reset clears the window pointer, the fill count and the fill byte; the
// history memory itself is not cleared, and takes no clearing pass.
`default_nettype none

module lz77_window_decoder_core #(
  parameter int WINDOW    = lzwd_pkg::DEF_WINDOW,
  parameter int MAX_MATCH = lzwd_pkg::DEF_MAX_MATCH
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [lzwd_pkg::BYTE_W-1:0]       cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [lzwd_pkg::OFF_W-1:0]        match_offset_i,
  input  wire logic [lzwd_pkg::LEN_W-1:0]        match_length_i,
  input  wire logic [lzwd_pkg::BYTE_W-1:0]       literal_i,
  input  wire logic                              new_stream_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [lzwd_pkg::BYTE_W-1:0]       data_byte_o,
  output logic                                   last_o
);
  import lzwd_pkg::*;

  localparam int AW = $clog2(WINDOW);

  logic              issue;
  logic              issue_ok;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     slot_addr;
  byte_ctrl_t        ctrl;
  logic [BYTE_W-1:0] lit;
  logic [BYTE_W-1:0] rdata;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [BYTE_W-1:0] wdata;

  lzwd_seq #(
    .WINDOW    (WINDOW),
    .MAX_MATCH (MAX_MATCH)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .match_offset_i (match_offset_i),
    .match_length_i (match_length_i),
    .literal_i      (literal_i),
    .new_stream_i   (new_stream_i),
    .issue_ok_i     (issue_ok),
    .issue_o        (issue),
    .raddr_o        (raddr),
    .waddr_o        (slot_addr),
    .ctrl_o         (ctrl),
    .lit_o          (lit)
  );

  lzwd_ram #(
    .DEPTH (WINDOW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (issue),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  lzwd_out #(
    .WINDOW (WINDOW)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .issue_i     (issue),
    .raddr_i     (raddr),
    .waddr_i     (slot_addr),
    .ctrl_i      (ctrl),
    .lit_i       (lit),
    .issue_ok_o  (issue_ok),
    .rdata_i     (rdata),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_byte_o (data_byte_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

// ----- src/lzwd_check.sv -----
`default_nettype none

`include "lz77_window_decoder_core_assert.svh"

module lzwd_check (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [lzwd_pkg::BYTE_W-1:0]       cfg_wdata_i,
  input  wire logic                              in_valid_i,
  input  wire logic                              in_stall_o,
  input  wire logic [lzwd_pkg::OFF_W-1:0]        match_offset_i,
  input  wire logic [lzwd_pkg::LEN_W-1:0]        match_length_i,
  input  wire logic [lzwd_pkg::BYTE_W-1:0]       literal_i,
  input  wire logic                              new_stream_i,
  input  wire logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  input  wire logic [lzwd_pkg::BYTE_W-1:0]       data_byte_o,
  input  wire logic                              last_o
);

  // a held result keeps its valid and its payload
  `LZWD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(data_byte_o) && $stable(last_o), "stalled output changed")

  // output valid only drops after the byte was taken
  `LZWD_ASSERT_IMPL(a_out_drop, clk_i, rst_ni, $fell(out_valid_o),
    $past(!out_stall_i), "output dropped while stalled")

  // one token at a time: a taken request closes the input
  `LZWD_ASSERT_NEXT(a_one_token, clk_i, rst_ni, in_valid_i && !in_stall_o,
    in_stall_o, "input open right after a request")

  // bytes of one run leave back to back
  `LZWD_ASSERT_NEXT(a_run_gapless, clk_i, rst_ni, out_valid_o && !out_stall_i && !last_o,
    out_valid_o, "gap inside a decoded run")

endmodule

bind lz77_window_decoder_core lzwd_check u_check (.*);

`default_nettype wire

// ----- tb/lz77_window_decoder_checker.sv -----
`timescale 1ns / 1ps

module lz77_window_decoder_checker #(
  parameter int WINDOW    = lzwd_pkg::DEF_WINDOW,
  parameter int MAX_MATCH = lzwd_pkg::DEF_MAX_MATCH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lzwd_pkg::BYTE_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [lzwd_pkg::OFF_W-1:0]  match_offset_i,
  input  logic [lzwd_pkg::LEN_W-1:0]  match_length_i,
  input  logic [lzwd_pkg::BYTE_W-1:0] literal_i,
  input  logic                        new_stream_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [lzwd_pkg::BYTE_W-1:0] data_byte_i,
  input  logic                        last_i,
  output int                          err_count_o,
  output int                          pending_o
);

  typedef struct packed {
    logic [lzwd_pkg::BYTE_W-1:0] data;
    logic                        last;
  } dec_byte_t;

  // model of the sliding window
  logic [lzwd_pkg::BYTE_W-1:0] win_mem [WINDOW];
  logic [lzwd_pkg::OFF_W-1:0]  win_head;
  logic [lzwd_pkg::OFF_W:0]    win_cnt;
  logic [lzwd_pkg::BYTE_W-1:0] fill_byte;

  dec_byte_t decoded_bytes_q[$];
  dec_byte_t exp_byte;
  int        mismatch_cnt = 0;

  task automatic report_mismatch(input string what);
    if (mismatch_cnt < 50) $display("%0t: mismatch: %s", $time, what);
    mismatch_cnt++;
  endtask

  function automatic void store_byte(input logic [lzwd_pkg::BYTE_W-1:0] b);
    win_mem[win_head] = b;
    win_head = (int'(win_head) == WINDOW - 1) ? '0 : win_head + 1'b1;
    if (int'(win_cnt) < WINDOW) win_cnt = win_cnt + 1'b1;
  endfunction

  function automatic void decode_token(input logic [lzwd_pkg::OFF_W-1:0]  off,
                                       input logic [lzwd_pkg::LEN_W-1:0]  len,
                                       input logic [lzwd_pkg::BYTE_W-1:0] lit,
                                       input logic                        restart);
    int                          off_sat;
    int                          n_copy;
    int                          back_dist;
    int                          idx;
    logic [lzwd_pkg::BYTE_W-1:0] b;
    if (restart) begin
      win_head = '0;
      win_cnt  = '0;
    end
    off_sat   = (int'(off) >= WINDOW) ? WINDOW - 1 : int'(off);
    n_copy    = (int'(len) > MAX_MATCH - 1) ? MAX_MATCH - 1 : int'(len);
    back_dist = WINDOW - off_sat;
    for (int i = 0; i < n_copy; i++) begin
      // copies further back than the stream has written read as fill
      if (back_dist > int'(win_cnt)) begin
        b = fill_byte;
      end else begin
        idx = (int'(win_head) + WINDOW - back_dist) % WINDOW;
        b   = win_mem[idx];
      end
      store_byte(b);
      decoded_bytes_q.push_back('{data: b, last: 1'b0});
    end
    store_byte(lit);
    decoded_bytes_q.push_back('{data: lit, last: 1'b1});
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_head  = '0;
      win_cnt   = '0;
      fill_byte = '0;
      decoded_bytes_q.delete();
      pending_o   <= 0;
      err_count_o <= 0;
    end else begin
      // check outputs before taking a new request, a byte never belongs
      // to a token taken at the same edge
      if (out_valid_i && !out_stall_i) begin
        if (decoded_bytes_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %0b", data_byte_i, last_i));
        end else begin
          exp_byte = decoded_bytes_q.pop_front();
          if (data_byte_i !== exp_byte.data)
            report_mismatch($sformatf("data_byte %02h, expected %02h",
                                      data_byte_i, exp_byte.data));
          if (last_i !== exp_byte.last)
            report_mismatch($sformatf("last %0b, expected %0b on byte %02h",
                                      last_i, exp_byte.last, exp_byte.data));
        end
      end
      if (cfg_we_i) fill_byte = cfg_wdata_i;
      if (in_valid_i && !in_stall_i)
        decode_token(match_offset_i, match_length_i, literal_i, new_stream_i);
      pending_o   <= decoded_bytes_q.size();
      err_count_o <= mismatch_cnt;
    end
  end

endmodule

// ----- tb/tb_lz77_window_decoder_core.sv -----
`timescale 1ns / 1ps

module tb_lz77_window_decoder_core;

  localparam int RAND_PHASES     = 4;
  localparam int ITEMS_PER_PHASE = 55;
  localparam int LONG_HOLD       = 200;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [lzwd_pkg::BYTE_W-1:0] cfg_wdata;
  logic                        in_valid;
  logic                        in_stall;
  logic [lzwd_pkg::OFF_W-1:0]  match_offset;
  logic [lzwd_pkg::LEN_W-1:0]  match_length;
  logic [lzwd_pkg::BYTE_W-1:0] literal;
  logic                        new_stream;
  logic                        out_valid;
  logic                        out_stall;
  logic [lzwd_pkg::BYTE_W-1:0] data_byte;
  logic                        last_byte;
  int                          err_count;
  int                          pending;

  bit quiet         = 1'b0;
  bit long_hold_req = 1'b0;

  lz77_window_decoder_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .match_offset_i (match_offset),
    .match_length_i (match_length),
    .literal_i      (literal),
    .new_stream_i   (new_stream),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .data_byte_o    (data_byte),
    .last_o         (last_byte)
  );

  lz77_window_decoder_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .match_offset_i (match_offset),
    .match_length_i (match_length),
    .literal_i      (literal),
    .new_stream_i   (new_stream),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .data_byte_i    (data_byte),
    .last_i         (last_byte),
    .err_count_o    (err_count),
    .pending_o      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("tb_lz77_window_decoder_core failed");
    $finish;
  end

  // output side: random stall bursts, plus one long hold on request
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_token(input logic [lzwd_pkg::OFF_W-1:0]  off,
                            input logic [lzwd_pkg::LEN_W-1:0]  len,
                            input logic [lzwd_pkg::BYTE_W-1:0] lit,
                            input logic                        restart);
    in_valid     <= 1'b1;
    match_offset <= off;
    match_length <= len;
    literal      <= lit;
    new_stream   <= restart;
    do @(posedge clk); while (in_stall);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // stop offering and wait until every decoded byte has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_fill(input logic [lzwd_pkg::BYTE_W-1:0] value);
    drain();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [lzwd_pkg::OFF_W-1:0]  off;
    logic [lzwd_pkg::LEN_W-1:0]  len;
    logic [lzwd_pkg::BYTE_W-1:0] fill_val;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    match_offset = '0;
    match_length = '0;
    literal      = '0;
    new_stream   = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset fill, extremes, overlapping copies, restart
    send_token(10'd0, 4'd0, 8'h00, 1'b0);
    send_token(10'd0, 4'd15, 8'hff, 1'b0);
    send_token(10'd1023, 4'd15, 8'h5a, 1'b0);
    send_token(10'd1020, 4'd8, 8'h01, 1'b0);
    send_token(10'd1000, 4'd15, 8'h80, 1'b0);
    send_token(10'h2aa, 4'ha, 8'haa, 1'b0);
    send_token(10'h155, 4'h5, 8'h55, 1'b0);
    send_token(10'd1023, 4'd1, 8'h7f, 1'b0);
    // fill changed mid-stream
    write_fill(8'hc3);
    send_token(10'd0, 4'd15, 8'h3c, 1'b0);
    send_token(10'd512, 4'd4, 8'h12, 1'b0);
    send_token(10'd1022, 4'd6, 8'hfe, 1'b0);
    // restart: window reads as fill again
    send_token(10'd1023, 4'd3, 8'h80, 1'b1);
    send_token(10'd1021, 4'd15, 8'h00, 1'b0);
    send_token(10'd0, 4'd2, 8'hff, 1'b1);
    send_token(10'd1023, 4'd0, 8'h01, 1'b1);
    send_token(10'd1010, 4'd15, 8'h99, 1'b0);

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       fill_val = 8'hff;
        1:       fill_val = 8'h00;
        2:       fill_val = 8'($urandom);
        default: fill_val = 8'h7e;
      endcase
      write_fill(fill_val);
      if (p == 1) long_hold_req = 1'b1;
      if (p == RAND_PHASES - 1) quiet = 1'b1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == 2 && k == ITEMS_PER_PHASE / 2) drain();
        case ($urandom_range(0, 9))
          0:       off = $urandom_range(0, 1) ? 10'd0 : 10'd1023;
          1, 2, 3: off = 10'($urandom_range(1008, 1023));
          default: off = 10'($urandom_range(0, 1023));
        endcase
        len = ($urandom_range(0, 5) == 0) ? 4'd15 : 4'($urandom_range(0, 15));
        send_token(off, len, 8'($urandom), $urandom_range(0, 39) == 0);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_lz77_window_decoder_core passed");
    end else begin
      $display("tb_lz77_window_decoder_core failed");
    end
    $finish;
  end

endmodule
